@@ sv/gcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared constants for the great-circle distance pipeline: fixed-point angle
// constants in Q30, the arctangent table and the field widths.
// ----------------------------------------------------------------------------
package gcd_pkg;

    // defaults for the top-level parameters
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // internal angle format
    localparam int Q_BITS = 30;

    // field widths
    localparam int ANG_W  = 20;
    localparam int RAD_W  = 24;
    localparam int DIST_W = 27;
    localparam int IN_W   = 128;
    localparam int OUT_W  = 32;

    // datapath widths
    localparam int XW  = 34;   // CORDIC x/y
    localparam int ZW  = 35;   // reduced angles, CORDIC z
    localparam int MW  = 32;   // sin/cos values and clamped cosine
    localparam int SQW = 61;   // radicand of the square root
    localparam int ISQ_N = 31; // result bits of the square root

    // Q30 constants
    localparam logic signed [63:0] PI_Q      = 64'sd3373259426;
    localparam logic signed [63:0] TWO_PI_Q  = 64'sd6746518852;
    localparam logic signed [63:0] HALF_PI_Q = 64'sd1686629713;
    localparam logic signed [63:0] GAIN_Q    = 64'sd652032874;
    localparam logic signed [63:0] ONE_Q     = 64'sd1073741824;

    // atan(2^-i) in Q30, truncated
    localparam int ATAN_LEN = 28;
    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7
    };

endpackage

`default_nettype wire

@@ sv/great_circle_distance_unit.sv @@
`default_nettype none
// The two CORDIC chains and the square root set most of the pipeline depth.
// Throughput: one beat per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset clears the valid bits only; the datapath registers carry no reset.
// ----------------------------------------------------------------------------
// great_circle_distance_unit
// Spherical law of cosines: three CORDIC sin/cos lanes, products, clamp,
// bit-per-stage square root, vectoring CORDIC acos and mean-radius scaling.
// ----------------------------------------------------------------------------
module great_circle_distance_unit
    import gcd_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // colat_first, lon_first, radius_first, colat_second, lon_second, radius_second
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // arc_distance, zero padded
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int SH     = Q_BITS - FRAC_BITS;
    localparam int AW     = ANG_W + SH + 1;
    localparam int RW     = (AW > 34) ? AW : 34;
    localparam int RED_N  = (AW > 34) ? AW - 33 : 1;
    localparam int N      = CORDIC_STEPS;
    localparam int RS_LEN = RED_N + 2 * N + 42;
    localparam int LAT    = RS_LEN + 2;
    localparam int IDX_P4 = RED_N + N + 7;
    localparam int IDX_SQ = RED_N + N + 40;

    // ---------------- flow control ----------------
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // ---------------- input unpack, Q30 conversion ----------------
    logic signed [ANG_W-1:0] colat1, lon1, colat2, lon2;
    logic signed [RAD_W-1:0] rad1, rad2;
    logic signed [AW-1:0]    ang_in [3];

    assign colat1 = $signed(s_tdata[19:0]);
    assign lon1   = $signed(s_tdata[39:20]);
    assign rad1   = $signed(s_tdata[63:40]);
    assign colat2 = $signed(s_tdata[83:64]);
    assign lon2   = $signed(s_tdata[103:84]);
    assign rad2   = $signed(s_tdata[127:104]);

    assign ang_in[0] = AW'(colat1) <<< SH;
    assign ang_in[1] = AW'(colat2) <<< SH;
    assign ang_in[2] = (AW'(lon1) <<< SH) - (AW'(lon2) <<< SH);

    // radius sum delay line
    logic signed [RAD_W:0] rs_reg [RS_LEN];

    always_ff @(posedge aclk) begin
        if (adv) begin
            rs_reg[0] <= (RAD_W+1)'(rad1) + (RAD_W+1)'(rad2);
            for (int k = 1; k < RS_LEN; k++) begin
                rs_reg[k] <= rs_reg[k-1];
            end
        end
    end

    // ---------------- range reduction: |a| mod 2*pi ----------------
    logic [RW-1:0] mag_reg [RED_N+1][3];
    logic          sgn_reg [RED_N+1][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                sgn_reg[0][l] <= ang_in[l][AW-1];
                mag_reg[0][l] <= RW'($unsigned(ang_in[l][AW-1] ? -ang_in[l] : ang_in[l]));
            end
        end
    end

    for (genvar j = 0; j < RED_N; j++) begin : g_red
        localparam logic [63:0] STEP_W = TWO_PI_Q << (RED_N - 1 - j);
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    sgn_reg[j+1][l] <= sgn_reg[j][l];
                    if (mag_reg[j][l] >= RW'(STEP_W)) begin
                        mag_reg[j+1][l] <= mag_reg[j][l] - RW'(STEP_W);
                    end else begin
                        mag_reg[j+1][l] <= mag_reg[j][l];
                    end
                end
            end
        end
    end

    // signed remainder, wrapped into [-pi, pi]
    logic signed [ZW-1:0] na_reg [3];
    logic signed [ZW-1:0] na_next [3];

    always_comb begin
        logic signed [ZW-1:0] r;
        for (int l = 0; l < 3; l++) begin
            r = $signed(ZW'(mag_reg[RED_N][l]));
            if (sgn_reg[RED_N][l]) begin
                r = -r;
            end
            if (r > ZW'(PI_Q)) begin
                na_next[l] = r - ZW'(TWO_PI_Q);
            end else if (r < -ZW'(PI_Q)) begin
                na_next[l] = r + ZW'(TWO_PI_Q);
            end else begin
                na_next[l] = r;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            na_reg <= na_next;
        end
    end

    // ---------------- fold to [-pi/2, pi/2], rotation CORDIC ----------------
    logic signed [XW-1:0] rx_reg [N+1][3];
    logic signed [XW-1:0] ry_reg [N+1][3];
    logic signed [ZW-1:0] rz_reg [N+1][3];
    logic                 neg_reg [N+1][3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < 3; l++) begin
                rx_reg[0][l] <= XW'(GAIN_Q);
                ry_reg[0][l] <= '0;
                if (na_reg[l] > ZW'(HALF_PI_Q)) begin
                    rz_reg[0][l]  <= ZW'(PI_Q) - na_reg[l];
                    neg_reg[0][l] <= 1'b1;
                end else if (na_reg[l] < -ZW'(HALF_PI_Q)) begin
                    rz_reg[0][l]  <= -ZW'(PI_Q) - na_reg[l];
                    neg_reg[0][l] <= 1'b1;
                end else begin
                    rz_reg[0][l]  <= na_reg[l];
                    neg_reg[0][l] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int l = 0; l < 3; l++) begin
                    neg_reg[i+1][l] <= neg_reg[i][l];
                    if (rz_reg[i][l] >= 0) begin
                        rx_reg[i+1][l] <= rx_reg[i][l] - (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] + (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] - ZW'(ATAN_TAB[i]);
                    end else begin
                        rx_reg[i+1][l] <= rx_reg[i][l] + (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] - (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] + ZW'(ATAN_TAB[i]);
                    end
                end
            end
        end
    end

    // ---------------- cosine of the central angle ----------------
    logic signed [MW-1:0]   sn_reg [3];
    logic signed [MW-1:0]   cs_reg [3];
    logic signed [63:0]     pcc_reg, pss_reg;
    logic signed [MW-1:0]   cd1_reg, cd2_reg;
    logic signed [XW-1:0]   cc2_reg, ss2_reg, cc3_reg;
    logic signed [XW+MW-1:0] pm3_reg;
    logic signed [XW+1:0]   sum_next;
    logic signed [MW-1:0]   c4_reg, c5_reg;
    logic [SQW-1:0]         csq5_reg;
    logic signed [63:0]     csq_full;

    assign sum_next = (XW+2)'(cc3_reg) + (XW+2)'(pm3_reg >>> Q_BITS);
    assign csq_full = 64'(c4_reg) * 64'(c4_reg);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // sin/cos with the fold sign
            for (int l = 0; l < 3; l++) begin
                sn_reg[l] <= MW'(ry_reg[N][l]);
                cs_reg[l] <= neg_reg[N][l] ? MW'(-rx_reg[N][l]) : MW'(rx_reg[N][l]);
            end
            // cos1*cos2, sin1*sin2
            pcc_reg <= 64'(cs_reg[0]) * 64'(cs_reg[1]);
            pss_reg <= 64'(sn_reg[0]) * 64'(sn_reg[1]);
            cd1_reg <= cs_reg[2];
            // back to Q30
            cc2_reg <= XW'(pcc_reg >>> Q_BITS);
            ss2_reg <= XW'(pss_reg >>> Q_BITS);
            cd2_reg <= cd1_reg;
            // sin product times cos of longitude difference
            pm3_reg <= (XW+MW)'(ss2_reg) * (XW+MW)'(cd2_reg);
            cc3_reg <= cc2_reg;
            // sum and clamp to [-1, 1]
            if (sum_next > (XW+2)'(ONE_Q)) begin
                c4_reg <= MW'(ONE_Q);
            end else if (sum_next < -(XW+2)'(ONE_Q)) begin
                c4_reg <= -MW'(ONE_Q);
            end else begin
                c4_reg <= MW'(sum_next);
            end
            // c squared
            csq5_reg <= csq_full[SQW-1:0];
            c5_reg   <= c4_reg;
        end
    end

    // ---------------- sqrt(1 - c^2), one result bit per stage ----------------
    logic [SQW-1:0]       isv_reg [ISQ_N+1];
    logic [SQW:0]         isr_reg [ISQ_N+1];
    logic signed [MW-1:0] cq_reg  [ISQ_N+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            isv_reg[0] <= (SQW'(1) << (2 * Q_BITS)) - csq5_reg;
            isr_reg[0] <= '0;
            cq_reg[0]  <= c5_reg;
        end
    end

    for (genvar j = 0; j < ISQ_N; j++) begin : g_sqrt
        localparam logic [SQW:0] BIT_C = (SQW+1)'(1) << (2 * Q_BITS - 2 * j);
        logic [SQW:0] trial;
        assign trial = isr_reg[j] + BIT_C;
        always_ff @(posedge aclk) begin
            if (adv) begin
                cq_reg[j+1] <= cq_reg[j];
                if ({1'b0, isv_reg[j]} >= trial) begin
                    isv_reg[j+1] <= isv_reg[j] - SQW'(trial);
                    isr_reg[j+1] <= (isr_reg[j] >> 1) + BIT_C;
                end else begin
                    isv_reg[j+1] <= isv_reg[j];
                    isr_reg[j+1] <= isr_reg[j] >> 1;
                end
            end
        end
    end

    // ---------------- arccosine by vectoring CORDIC ----------------
    logic signed [XW-1:0] vx_reg [N+1];
    logic signed [XW-1:0] vy_reg [N+1];
    logic signed [ZW-1:0] vz_reg [N+1];
    logic signed [XW-1:0] sq_val;
    logic signed [XW-1:0] cq_val;

    assign sq_val = $signed(XW'(isr_reg[ISQ_N][ISQ_N-1:0]));
    assign cq_val = XW'(cq_reg[ISQ_N]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (cq_val < 0) begin
                vx_reg[0] <= sq_val;
                vy_reg[0] <= -cq_val;
                vz_reg[0] <= ZW'(HALF_PI_Q);
            end else begin
                vx_reg[0] <= cq_val;
                vy_reg[0] <= sq_val;
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        always_ff @(posedge aclk) begin
            if (adv) begin
                if (vy_reg[i] > 0) begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ZW'(ATAN_TAB[i]);
                end else begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ZW'(ATAN_TAB[i]);
                end
            end
        end
    end

    // ---------------- scale by mean radius, round, saturate ----------------
    localparam int DPW = ZW + RAD_W + 1;
    logic signed [DPW-1:0]  dp_reg;
    logic signed [DPW-1:0]  rnd;
    logic signed [DPW-1:0]  dsh;
    logic signed [DIST_W-1:0] out_reg;
    localparam logic signed [DPW-1:0] D_HI = DPW'((64'sd1 <<< (DIST_W - 1)) - 64'sd1);
    localparam logic signed [DPW-1:0] D_LO = DPW'(-(64'sd1 <<< (DIST_W - 1)));

    assign rnd = dp_reg + (DPW'(1) <<< Q_BITS);
    assign dsh = rnd >>> (Q_BITS + 1);

    always_ff @(posedge aclk) begin
        if (adv) begin
            dp_reg <= DPW'(vz_reg[N]) * DPW'(rs_reg[RS_LEN-1]);
            if (dsh > D_HI) begin
                out_reg <= DIST_W'(D_HI);
            end else if (dsh < D_LO) begin
                out_reg <= DIST_W'(D_LO);
            end else begin
                out_reg <= DIST_W'(dsh);
            end
        end
    end

    assign m_tdata = {{(OUT_W - DIST_W){1'b0}}, out_reg};

`ifndef ASSERT_OFF
    // a stall freezes every valid bit
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    // an accepted beat occupies the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat missing from the first stage");

    // clamped cosine stays within [-1, 1]
    a_clamp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[IDX_P4] |-> (c4_reg <= MW'(ONE_Q)) && (c4_reg >= -MW'(ONE_Q)))
        else $error("clamped cosine out of range");

    // square root of a value up to 2^60 never exceeds 2^30
    a_sqrt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[IDX_SQ] |-> (isr_reg[ISQ_N] <= (SQW+1)'(ONE_Q)))
        else $error("square root result out of range");
`endif

endmodule

`default_nettype wire
